// ===== rtl/core/rpn_pkg.sv =====
// Shared types, codes and widths of the RPN stack calculator.
`default_nettype none
package rpn_pkg;

  localparam int VAL_W           = 32;
  localparam int OP_W            = 3;
  localparam int ST_W            = 2;
  localparam int FRAC_W          = 16;
  localparam int DIV_STEPS       = VAL_W + FRAC_W;
  localparam int DEF_STACK_DEPTH = 64;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_DROP = 3'd5;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_FEW  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP2,
    CMD_DROP
  } stack_cmd_e;

  typedef struct packed {
    logic shift_down;
    logic shift_up;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/rpn_cell.sv =====
// One stack entry: holds, takes the entry above or takes the entry below.
`default_nettype none
module rpn_cell (
  input  wire logic                     clk_i,
  input  wire rpn_pkg::cell_ctl_t       ctl_i,
  input  wire logic [rpn_pkg::VAL_W-1:0] prev_i,
  input  wire logic [rpn_pkg::VAL_W-1:0] next_i,
  output logic      [rpn_pkg::VAL_W-1:0] data_o
);
  import rpn_pkg::*;

  logic [VAL_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_down) begin
      data_d = prev_i;
    end else if (ctl_i.shift_up) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/rpn_div.sv =====
// Shift-subtract Q16.16 divider, one quotient bit per cycle, saturating result.
`default_nettype none
module rpn_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rpn_pkg::VAL_W-1:0] dividend_i,
  input  wire logic [rpn_pkg::VAL_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [rpn_pkg::VAL_W-1:0] quot_o
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int Q_W   = DIV_STEPS;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [Q_W-1:0]   q_q, q_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;

  logic [VAL_W-1:0] a_mag, b_mag;
  logic [VAL_W:0]   rem_sh;
  logic             ge;
  logic             last;

  assign a_mag  = dividend_i[VAL_W-1] ? VAL_W'(-dividend_i) : dividend_i;
  assign b_mag  = divisor_i[VAL_W-1] ? VAL_W'(-divisor_i) : divisor_i;
  assign rem_sh = {rem_q, q_q[Q_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign last   = cnt_q == CNT_W'(DIV_STEPS - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    q_d    = q_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      q_d    = {a_mag, {FRAC_W{1'b0}}};
      dvs_d  = b_mag;
      neg_d  = dividend_i[VAL_W-1] ^ divisor_i[VAL_W-1];
    end else if (busy_q) begin
      rem_d = ge ? VAL_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[VAL_W-1:0];
      q_d   = {q_q[Q_W-2:0], ge};
      cnt_d = CNT_W'(cnt_q + 1'b1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      if ((|q_q[Q_W-1:VAL_W]) || (q_q[VAL_W-1] && (|q_q[VAL_W-2:0]))) begin
        quot_o = VAL_MIN;
      end else begin
        quot_o = VAL_W'(-q_q[VAL_W-1:0]);
      end
    end else begin
      if (|q_q[Q_W-1:VAL_W-1]) begin
        quot_o = VAL_MAX;
      end else begin
        quot_o = q_q[VAL_W-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator: control, arithmetic and the row of stack cells.
// Postfix calculator over a stack of signed Q16.16 entries held in a row of cells, top
// entry in the first cell; push shifts the row down, drop and binary operations shift it
// up. One beat is taken at a time. Push, drop, add, subtract and rejected beats pass the
// execute and commit states; multiply adds a multiply state (registered product, then
// shift and saturate), divide a state waiting on the 48-step shift-subtract divider.
// Results saturate; a full stack, too few entries or a zero divisor sets status. The
// result register lets a new beat be accepted while the previous result is still stalled.
`default_nettype none
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [rpn_pkg::OP_W-1:0]            opcode_i,
  input  wire logic signed [rpn_pkg::VAL_W-1:0]    operand_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [rpn_pkg::VAL_W-1:0]         top_value_o,
  output logic      [rpn_pkg::ST_W-1:0]            status_o,
  output logic      [$clog2(STACK_DEPTH+1)-1:0]    depth_o
);
  import rpn_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q, out_valid_d;

  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] res_q, res_d;
  logic [ST_W-1:0]  st_q, st_d;
  stack_cmd_e       cmd_q, cmd_d;
  logic signed [2*VAL_W-1:0] prod_q;
  logic [VAL_W-1:0] top_q, top_d;
  logic [ST_W-1:0]  ost_q, ost_d;
  logic [CW-1:0]    odep_q, odep_d;

  logic             in_fire;
  logic             out_free;
  logic             div_start;
  logic             div_done;
  logic [VAL_W-1:0] div_res;
  logic [VAL_W-1:0] cell_data [STACK_DEPTH];
  logic [VAL_W-1:0] op_a, op_b;
  logic [VAL_W:0]   sum_ab, dif_ab;
  logic [VAL_W-1:0] mul_sat;
  cell_ctl_t        head_ctl, body_ctl;

  function automatic logic [VAL_W-1:0] sat_wide(input logic [VAL_W:0] x);
    if (x[VAL_W] != x[VAL_W-1]) begin
      return x[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return x[VAL_W-1:0];
  endfunction

  assign in_stall_o = state_q != S_IDLE;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign op_a   = cell_data[1];
  assign op_b   = cell_data[0];
  assign sum_ab = {op_a[VAL_W-1], op_a} + {op_b[VAL_W-1], op_b};
  assign dif_ab = {op_a[VAL_W-1], op_a} - {op_b[VAL_W-1], op_b};

  always_comb begin
    if ((&prod_q[2*VAL_W-1:VAL_W+FRAC_W-1]) || !(|prod_q[2*VAL_W-1:VAL_W+FRAC_W-1])) begin
      mul_sat = prod_q[VAL_W+FRAC_W-1:FRAC_W];
    end else begin
      mul_sat = prod_q[2*VAL_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    st_d        = st_q;
    cmd_d       = cmd_q;
    top_d       = top_q;
    ost_d       = ost_q;
    odep_d      = odep_q;
    div_start   = 1'b0;
    head_ctl    = '0;
    body_ctl    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        st_d    = ST_OK;
        cmd_d   = CMD_HOLD;
        state_d = S_COMMIT;
        unique case (op_q) inside
          OP_PUSH: begin
            if (count_q >= CW'(STACK_DEPTH)) begin
              st_d = ST_FULL;
            end else begin
              cmd_d = CMD_PUSH;
              res_d = val_q;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (count_q < CW'(2)) begin
              st_d = ST_FEW;
            end else begin
              cmd_d = CMD_POP2;
              unique case (op_q) inside
                OP_ADD: res_d = sat_wide(sum_ab);
                OP_SUB: res_d = sat_wide(dif_ab);
                OP_MUL: state_d = S_MUL;
                default: begin
                  if (op_b == '0) begin
                    st_d  = ST_DIV0;
                    res_d = op_a[VAL_W-1] ? VAL_MIN : ((op_a == '0) ? '0 : VAL_MAX);
                  end else begin
                    div_start = 1'b1;
                    state_d   = S_DIV;
                  end
                end
              endcase
            end
          end
          OP_DROP: begin
            if (count_q == '0) begin
              st_d = ST_FEW;
            end else begin
              cmd_d = CMD_DROP;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        res_d   = mul_sat;
        state_d = S_COMMIT;
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_res;
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ost_d       = st_q;
          state_d     = S_IDLE;
          unique case (cmd_q)
            CMD_PUSH: begin
              count_d             = CW'(count_q + 1'b1);
              top_d               = res_q;
              head_ctl.shift_down = 1'b1;
              body_ctl.shift_down = 1'b1;
            end
            CMD_POP2: begin
              count_d             = CW'(count_q - 1'b1);
              top_d               = res_q;
              head_ctl.shift_down = 1'b1;
              body_ctl.shift_up   = 1'b1;
            end
            CMD_DROP: begin
              count_d           = CW'(count_q - 1'b1);
              top_d             = (count_q > CW'(1)) ? cell_data[1] : '0;
              head_ctl.shift_up = 1'b1;
              body_ctl.shift_up = 1'b1;
            end
            default: begin
              top_d = (count_q != '0) ? cell_data[0] : '0;
            end
          endcase
          odep_d = count_d;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_i;
      val_q <= operand_value_i;
    end
    if (state_q == S_EXEC) begin
      prod_q <= $signed(op_a) * $signed(op_b);
    end
    res_q  <= res_d;
    st_q   <= st_d;
    cmd_q  <= cmd_d;
    top_q  <= top_d;
    ost_q  <= ost_d;
    odep_q <= odep_d;
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a),
    .divisor_i  (op_b),
    .done_o     (div_done),
    .quot_o     (div_res)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_head
      assign prev_w = res_q;
    end else begin : g_body
      assign prev_w = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_link
      assign next_w = cell_data[i+1];
    end
    rpn_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  ((i == 0) ? head_ctl : body_ctl),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign status_o    = ost_q;
  assign depth_o     = odep_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_count_at_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_COMMIT && out_free) |=> $stable(count_q))
    else $error("stack count changed outside commit");

  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_o == '0) |-> top_value_o == '0)
    else $error("empty stack shows nonzero top");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && out_free) |=> (out_valid_o && depth_o == count_q))
    else $error("commit result not presented");

endmodule
`default_nettype wire

// ===== test/rpn_checker.sv =====
// Checker for the RPN stack calculator: tracks the stack from accepted beats and compares results.
`timescale 1ns / 100ps
module rpn_checker #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [rpn_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [rpn_pkg::VAL_W-1:0]  operand_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [rpn_pkg::VAL_W-1:0]  top_value_i,
  input  logic [rpn_pkg::ST_W-1:0]          status_i,
  input  logic [DEPTH_W-1:0]                depth_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  import rpn_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] top;
    logic [ST_W-1:0]         status;
    logic [DEPTH_W-1:0]      depth;
  } calc_result_t;

  logic signed [VAL_W-1:0] stack_mem [STACK_DEPTH];
  int                      stack_count;
  calc_result_t            calc_results_q [$];
  int                      mismatch_count;
  int                      results_seen;
  int                      pending_count;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;
  assign checked_o    = results_seen;

  function automatic logic signed [VAL_W-1:0] sat_q16(longint x);
    if (x > longint'($signed(VAL_MAX))) return VAL_MAX;
    if (x < longint'($signed(VAL_MIN))) return VAL_MIN;
    return x[VAL_W-1:0];
  endfunction

  // Applies one beat to the tracked stack and returns the result it should produce.
  function automatic calc_result_t calc_apply(logic [OP_W-1:0] op,
                                              logic signed [VAL_W-1:0] val);
    calc_result_t            res;
    longint                  lhs;
    longint                  rhs;
    logic signed [VAL_W-1:0] r;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[stack_count] = val;
          stack_count++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (stack_count < 2) begin
          res.status = ST_FEW;
        end else begin
          lhs = stack_mem[stack_count-2];
          rhs = stack_mem[stack_count-1];
          case (op)
            OP_ADD: r = sat_q16(lhs + rhs);
            OP_SUB: r = sat_q16(lhs - rhs);
            OP_MUL: r = sat_q16((lhs * rhs) >>> FRAC_W);
            default: begin
              if (rhs == 0) begin
                res.status = ST_DIV0;
                r = (lhs > 0) ? VAL_MAX : ((lhs < 0) ? VAL_MIN : '0);
              end else begin
                r = sat_q16((lhs <<< FRAC_W) / rhs);
              end
            end
          endcase
          stack_count--;
          stack_mem[stack_count-1] = r;
        end
      end
      OP_DROP: begin
        if (stack_count == 0) res.status = ST_FEW;
        else stack_count--;
      end
      default: ;
    endcase
    res.depth = DEPTH_W'(stack_count);
    res.top   = (stack_count == 0) ? '0 : stack_mem[stack_count-1];
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: MISMATCH %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    calc_result_t want;
    if (!rst_ni) begin
      stack_count = 0;
      calc_results_q.delete();
      mismatch_count = 0;
      results_seen = 0;
      pending_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) calc_results_q.push_back(calc_apply(opcode_i, operand_value_i));
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (calc_results_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: top %h status %0d depth %0d",
                                  top_value_i, status_i, depth_i));
        end else begin
          want = calc_results_q.pop_front();
          if (top_value_i !== want.top)
            note_mismatch($sformatf("top_value expected %h got %h", want.top, top_value_i));
          if (status_i !== want.status)
            note_mismatch($sformatf("status expected %0d got %0d", want.status, status_i));
          if (depth_i !== want.depth)
            note_mismatch($sformatf("depth expected %0d got %0d", want.depth, depth_i));
        end
      end
      pending_count = calc_results_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the RPN stack calculator: beat stimulus, flow-control phases and verdict.
`timescale 1ns / 100ps
module tb_top;
  import rpn_pkg::*;

  localparam int STACK_DEPTH     = DEF_STACK_DEPTH;
  localparam int DEPTH_W         = $clog2(STACK_DEPTH + 1);
  localparam int BEATS_PER_PHASE = 206;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 64;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic [OP_W-1:0]         opcode        = OP_PUSH;
  logic signed [VAL_W-1:0] operand_value = '0;
  logic                    out_stall     = 1'b0;
  wire                     in_stall;
  wire                     out_valid;
  wire signed [VAL_W-1:0]  top_value;
  wire [ST_W-1:0]          status;
  wire [DEPTH_W-1:0]       depth;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int beats_sent  = 0;
  int stack_level = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;
  int checked;

  rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .operand_value_i (operand_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .top_value_o     (top_value),
    .status_o        (status),
    .depth_o         (depth)
  );

  rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .operand_value_i (operand_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .top_value_i     (top_value),
    .status_i        (status),
    .depth_i         (depth),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    operand_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
    case (op)
      OP_PUSH: if (stack_level < STACK_DEPTH) stack_level++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (stack_level >= 2) stack_level--;
      OP_DROP: if (stack_level > 0) stack_level--;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return (int'($urandom_range(0, 40)) - 20) <<< FRAC_W;
      4, 5: return int'($urandom_range(0, 524287)) - 262144;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_arith();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(int level);
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (roll < 12) return OP_DROP;
    if ((level < 2) ? (roll < 75) : (roll < 52)) return OP_PUSH;
    return pick_arith();
  endfunction

  task automatic fill_stack();
    int extra;
    extra = $urandom_range(1, 3);
    while (stack_level < STACK_DEPTH) send_beat(OP_PUSH, pick_operand());
    repeat (extra) send_beat(OP_PUSH, pick_operand());
  endtask

  task automatic drain_stack();
    int extra;
    extra = $urandom_range(1, 3);
    while (stack_level > 0)
      send_beat((stack_level > 1 && $urandom_range(1)) ? pick_arith() : OP_DROP, pick_operand());
    repeat (extra) send_beat($urandom_range(1) ? OP_DROP : pick_arith(), pick_operand());
  endtask

  task automatic run_phase(int idle, int stall, int beats);
    int stop_at;
    stop_at   = beats_sent + beats;
    idle_pct  = idle;
    stall_pct = stall;
    fill_stack();
    while (beats_sent < stop_at) begin
      case ($urandom_range(99))
        0: fill_stack();
        1, 2: drain_stack();
        default: send_beat(pick_opcode(stack_level), pick_operand());
      endcase
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty-stack rejects and spare opcodes
    send_beat(OP_DROP, '0);
    send_beat(OP_ADD, '0);
    send_beat(OP_SPARE_HI, VAL_MAX);
    send_beat(OP_PUSH, VAL_MAX);
    send_beat(OP_DIV, '0);
    // saturation at both ends
    send_beat(OP_PUSH, VAL_MAX);
    send_beat(OP_ADD, VAL_MIN);
    send_beat(OP_PUSH, VAL_MIN);
    send_beat(OP_SUB, '0);
    send_beat(OP_PUSH, VAL_MIN);
    send_beat(OP_MUL, '0);
    // divide by zero with negative, then zero dividend
    send_beat(OP_PUSH, '0);
    send_beat(OP_DIV, '0);
    send_beat(OP_PUSH, 32'sh0003_0000);
    send_beat(OP_PUSH, 32'shFFFE_0000);
    send_beat(OP_MUL, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_DIV, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_DIV, '0);
    send_beat(OP_SPARE_LO, '1);
    // product rounding toward minus infinity
    send_beat(OP_PUSH, 32'sh0000_0001);
    send_beat(OP_PUSH, -32'sh0000_0001);
    send_beat(OP_MUL, '0);

    run_phase(0, 0, BEATS_PER_PHASE);
    run_phase(50, 0, BEATS_PER_PHASE);
    run_phase(0, 50, BEATS_PER_PHASE);
    run_phase(34, 34, BEATS_PER_PHASE);

    in_valid <= 1'b0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: directed corners, stack fill and drain runs, random expressions,",
             beats_sent);
    $display("under four idle/stall mixes; %0d results compared field by field.", checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rpn_pkg.sv
rtl/core/rpn_cell.sv
rtl/core/rpn_div.sv
rtl/core/rpn_stack_calculator.sv
test/rpn_checker.sv
test/tb_top.sv
